FILE: hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is high
`define PFM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion, also checked while reset is high
`define PFM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/pfm_pkg.sv
// shared types, codes and constants of the pulse flow monitor
package pfm_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH         = 2;
   localparam int QUEUE_PTR_WIDTH     = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH     = $clog2(QUEUE_DEPTH + 1);
   localparam int TIME_WIDTH          = 32;
   localparam int GAP_WIDTH           = 20;
   localparam int WINDOW_WIDTH        = 16;
   localparam int CSR_INDEX_WIDTH     = 2;
   localparam int CSR_DATA_WIDTH      = 32;

   localparam logic [GAP_WIDTH-1:0]    FLOW_GAP_RESET    = GAP_WIDTH'(1000);
   localparam logic [GAP_WIDTH-1:0]    SCREW_GAP_RESET   = GAP_WIDTH'(5000);
   localparam logic [WINDOW_WIDTH-1:0] RATE_WINDOW_RESET = WINDOW_WIDTH'(1000);

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FLOW_GAP    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCREW_GAP   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RATE_WINDOW = 2'd2;

   localparam logic [2:0] OP_FLOW_EDGE  = 3'd0;
   localparam logic [2:0] OP_SCREW_EDGE = 3'd1;
   localparam logic [2:0] OP_RATE_POLL  = 3'd2;
   localparam logic [2:0] OP_LEAK_POLL  = 3'd3;
   localparam logic [2:0] OP_LEAK_REARM = 3'd4;
   localparam logic [2:0] OP_START      = 3'd5;

   typedef enum logic [2:0] {
      CMD_FLOW,
      CMD_SCREW,
      CMD_RATE,
      CMD_LEAK_POLL,
      CMD_REARM,
      CMD_START,
      CMD_NONE
   } cmd_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_MUL,
      BACK_DIV
   } back_state_type;

   typedef struct packed {
      logic [2:0]            opcode;
      logic [TIME_WIDTH-1:0] time_us;
      logic [TIME_WIDTH-1:0] time_ms;
      logic                  pump_running;
      logic [TIME_WIDTH-1:0] rearm_time_ms;
   } req_payload_type;

   typedef struct packed {
      logic        edge_accepted;
      logic [31:0] flow_total;
      logic [31:0] screw_total;
      logic [31:0] flow_rate;
      logic [31:0] leak_total;
      logic        leak_flag;
      logic        leak_ready;
   } rsp_payload_type;

   typedef struct packed {
      cmd_type               cmd;
      logic [TIME_WIDTH-1:0] time_us;
      logic [TIME_WIDTH-1:0] time_ms;
      logic                  pump_running;
      logic [TIME_WIDTH-1:0] rearm_time_ms;
   } queue_entry_type;

endpackage

FILE: hdl/pfm_front.sv
// front end: accepts requests, decodes the opcode and queues commands
module pfm_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  pfm_pkg::req_payload_type   req_data,
   output pfm_pkg::queue_entry_type   head,
   input  logic                       head_pop,
   output logic                       head_valid
);

   pfm_pkg::queue_entry_type                 entry_ff [pfm_pkg::QUEUE_DEPTH];
   pfm_pkg::queue_entry_type                 entry_in;
   logic [pfm_pkg::QUEUE_PTR_WIDTH-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [pfm_pkg::QUEUE_PTR_WIDTH-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [pfm_pkg::QUEUE_CNT_WIDTH-1:0]      count_ff, count_in;
   logic                                     push;
   logic                                     pop;
   pfm_pkg::cmd_type                         cmd;

   always_comb begin
      unique case (req_data.opcode)
         pfm_pkg::OP_FLOW_EDGE:  cmd = pfm_pkg::CMD_FLOW;
         pfm_pkg::OP_SCREW_EDGE: cmd = pfm_pkg::CMD_SCREW;
         pfm_pkg::OP_RATE_POLL:  cmd = pfm_pkg::CMD_RATE;
         pfm_pkg::OP_LEAK_POLL:  cmd = pfm_pkg::CMD_LEAK_POLL;
         pfm_pkg::OP_LEAK_REARM: cmd = pfm_pkg::CMD_REARM;
         pfm_pkg::OP_START:      cmd = pfm_pkg::CMD_START;
         default:                cmd = pfm_pkg::CMD_NONE;
      endcase
   end

   assign req_ready  = (count_ff != pfm_pkg::QUEUE_CNT_WIDTH'(pfm_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = head_pop && head_valid;

   always_comb begin
      entry_in.cmd           = cmd;
      entry_in.time_us       = req_data.time_us;
      entry_in.time_ms       = req_data.time_ms;
      entry_in.pump_running  = req_data.pump_running;
      entry_in.rearm_time_ms = req_data.rearm_time_ms;
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

FILE: hdl/pfm_divider.sv
// iterative restoring divider, one quotient bit per cycle
module pfm_divider #(
   parameter int COUNT_WIDTH = pfm_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [COUNT_WIDTH-1:0]            dividend,
   input  logic [pfm_pkg::TIME_WIDTH-1:0]    divisor,
   output logic                              done,
   output logic [COUNT_WIDTH-1:0]            quotient
);

   localparam int STEP_WIDTH = $clog2(COUNT_WIDTH + 1);

   logic [STEP_WIDTH-1:0]             steps_ff, steps_in;
   logic                              done_ff, done_in;
   logic [COUNT_WIDTH-1:0]            quo_ff, quo_in;
   logic [pfm_pkg::TIME_WIDTH-1:0]    rem_ff, rem_in;
   logic [pfm_pkg::TIME_WIDTH-1:0]    div_ff, div_in;
   logic [pfm_pkg::TIME_WIDTH:0]      rem_shift;
   logic [pfm_pkg::TIME_WIDTH:0]      rem_sub;
   logic                              fits;

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[COUNT_WIDTH-1]};
      fits      = rem_shift >= {1'b0, div_ff};
      rem_sub   = rem_shift - {1'b0, div_ff};
      steps_in  = steps_ff;
      done_in   = done_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      if (start) begin
         steps_in = STEP_WIDTH'(COUNT_WIDTH);
         done_in  = 1'b0;
         quo_in   = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (steps_ff != '0) begin
         steps_in = steps_ff - 1'b1;
         quo_in   = {quo_ff[COUNT_WIDTH-2:0], fits};
         rem_in   = fits ? rem_sub[pfm_pkg::TIME_WIDTH-1:0]
                         : rem_shift[pfm_pkg::TIME_WIDTH-1:0];
         if (steps_ff == STEP_WIDTH'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         steps_ff <= steps_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

endmodule

FILE: hdl/pfm_back.sv
// back end: counters, rate window, leak watch, csr registers and response register
module pfm_back #(
   parameter int COUNT_WIDTH = pfm_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   input  logic [pfm_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [pfm_pkg::CSR_DATA_WIDTH-1:0]     csr_data,
   input  pfm_pkg::queue_entry_type               head,
   input  logic                                   head_valid,
   output logic                                   head_pop,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output pfm_pkg::rsp_payload_type               rsp_data
);

   localparam int TW = pfm_pkg::TIME_WIDTH;

   function automatic logic [31:0] trim(input logic [COUNT_WIDTH-1:0] v);
      logic [63:0] wide;
      wide = 64'(v);
      return wide[31:0];
   endfunction

   pfm_pkg::back_state_type              state_ff, state_in;

   logic [pfm_pkg::GAP_WIDTH-1:0]        flow_gap_ff, screw_gap_ff;
   logic [pfm_pkg::WINDOW_WIDTH-1:0]     rate_window_ff;

   logic [COUNT_WIDTH-1:0] flow_count_ff, flow_count_in;
   logic [COUNT_WIDTH-1:0] screw_count_ff, screw_count_in;
   logic [TW-1:0]          flow_last_ff, flow_last_in;
   logic [TW-1:0]          screw_last_ff, screw_last_in;
   logic                   flow_fresh_ff, flow_fresh_in;
   logic                   screw_fresh_ff, screw_fresh_in;
   logic [TW-1:0]          window_start_ff, window_start_in;
   logic [COUNT_WIDTH-1:0] window_base_ff, window_base_in;
   logic [COUNT_WIDTH-1:0] held_rate_ff, held_rate_in;
   logic [TW-1:0]          rearm_time_ff, rearm_time_in;
   logic [COUNT_WIDTH-1:0] leak_base_ff, leak_base_in;
   logic [COUNT_WIDTH-1:0] leak_count_ff, leak_count_in;
   logic                   leak_armed_ff, leak_armed_in;
   logic [COUNT_WIDTH-1:0] num_ff, num_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   pfm_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [TW-1:0]                    elapsed;
   logic [pfm_pkg::WINDOW_WIDTH-1:0] window;
   logic                             rate_due;
   logic [COUNT_WIDTH-1:0]           pulses;
   logic [TW-1:0]                    flow_delta;
   logic [TW-1:0]                    screw_delta;
   logic [TW-1:0]                    rearm_delta;
   logic                             out_free;
   logic                             load;
   logic                             accepted;
   logic                             div_start;
   logic                             div_done;
   logic [COUNT_WIDTH-1:0]           div_quotient;

   pfm_divider #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_ff),
      .divisor  (elapsed),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         flow_gap_ff    <= pfm_pkg::FLOW_GAP_RESET;
         screw_gap_ff   <= pfm_pkg::SCREW_GAP_RESET;
         rate_window_ff <= pfm_pkg::RATE_WINDOW_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            pfm_pkg::CSR_FLOW_GAP:    flow_gap_ff    <= csr_data[pfm_pkg::GAP_WIDTH-1:0];
            pfm_pkg::CSR_SCREW_GAP:   screw_gap_ff   <= csr_data[pfm_pkg::GAP_WIDTH-1:0];
            pfm_pkg::CSR_RATE_WINDOW: rate_window_ff <= csr_data[pfm_pkg::WINDOW_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign elapsed     = head.time_ms - window_start_ff;
   assign window      = (rate_window_ff == '0) ? pfm_pkg::WINDOW_WIDTH'(1) : rate_window_ff;
   assign rate_due    = elapsed >= TW'(window);
   assign pulses      = flow_count_ff - window_base_ff;
   assign flow_delta  = head.time_us - flow_last_ff;
   assign screw_delta = head.time_us - screw_last_ff;
   assign rearm_delta = head.time_ms - rearm_time_ff;

   always_comb begin
      state_in        = state_ff;
      flow_count_in   = flow_count_ff;
      screw_count_in  = screw_count_ff;
      flow_last_in    = flow_last_ff;
      screw_last_in   = screw_last_ff;
      flow_fresh_in   = flow_fresh_ff;
      screw_fresh_in  = screw_fresh_ff;
      window_start_in = window_start_ff;
      window_base_in  = window_base_ff;
      held_rate_in    = held_rate_ff;
      rearm_time_in   = rearm_time_ff;
      leak_base_in    = leak_base_ff;
      leak_count_in   = leak_count_ff;
      leak_armed_in   = leak_armed_ff;
      num_in          = num_ff;
      accepted        = 1'b0;
      load            = 1'b0;
      div_start       = 1'b0;
      head_pop        = 1'b0;

      unique case (state_ff)
         pfm_pkg::BACK_IDLE: begin
            if (head_valid) begin
               if (head.cmd == pfm_pkg::CMD_RATE && rate_due) begin
                  // x1000 as 1024 - 16 - 8
                  num_in   = (pulses << 10) - (pulses << 4) - (pulses << 3);
                  state_in = pfm_pkg::BACK_MUL;
               end else if (out_free) begin
                  load     = 1'b1;
                  head_pop = 1'b1;
                  unique case (head.cmd)
                     pfm_pkg::CMD_FLOW: begin
                        if (flow_fresh_ff || flow_delta >= TW'(flow_gap_ff)) begin
                           accepted      = 1'b1;
                           flow_fresh_in = 1'b0;
                           flow_last_in  = head.time_us;
                           flow_count_in = flow_count_ff + COUNT_WIDTH'(1);
                        end
                     end
                     pfm_pkg::CMD_SCREW: begin
                        if (screw_fresh_ff || screw_delta >= TW'(screw_gap_ff)) begin
                           accepted       = 1'b1;
                           screw_fresh_in = 1'b0;
                           screw_last_in  = head.time_us;
                           screw_count_in = screw_count_ff + COUNT_WIDTH'(1);
                        end
                     end
                     pfm_pkg::CMD_LEAK_POLL: begin
                        if (head.pump_running) begin
                           leak_armed_in = 1'b0;
                           leak_base_in  = flow_count_ff;
                        end else if (!leak_armed_ff) begin
                           if (!rearm_delta[TW-1]) begin
                              leak_armed_in = 1'b1;
                           end
                           leak_base_in = flow_count_ff;
                        end else if (flow_count_ff > leak_base_ff) begin
                           leak_count_in = leak_count_ff + (flow_count_ff - leak_base_ff);
                           leak_base_in  = flow_count_ff;
                        end
                     end
                     pfm_pkg::CMD_REARM: begin
                        rearm_time_in = head.rearm_time_ms;
                        leak_armed_in = 1'b0;
                        leak_base_in  = flow_count_ff;
                     end
                     pfm_pkg::CMD_START: begin
                        flow_count_in   = '0;
                        screw_count_in  = '0;
                        flow_last_in    = '0;
                        screw_last_in   = '0;
                        flow_fresh_in   = 1'b1;
                        screw_fresh_in  = 1'b1;
                        window_start_in = head.time_ms;
                        window_base_in  = '0;
                        held_rate_in    = '0;
                        rearm_time_in   = head.time_ms;
                        leak_base_in    = '0;
                        leak_count_in   = '0;
                        leak_armed_in   = 1'b0;
                     end
                     default: ;
                  endcase
               end
            end
         end
         pfm_pkg::BACK_MUL: begin
            div_start = 1'b1;
            state_in  = pfm_pkg::BACK_DIV;
         end
         pfm_pkg::BACK_DIV: begin
            if (div_done && out_free) begin
               held_rate_in    = div_quotient;
               window_base_in  = flow_count_ff;
               window_start_in = head.time_ms;
               load            = 1'b1;
               head_pop        = 1'b1;
               state_in        = pfm_pkg::BACK_IDLE;
            end
         end
         default: state_in = pfm_pkg::BACK_IDLE;
      endcase

      rsp_data_in.edge_accepted = accepted;
      rsp_data_in.flow_total    = trim(flow_count_in);
      rsp_data_in.screw_total   = trim(screw_count_in);
      rsp_data_in.flow_rate     = trim(held_rate_in);
      rsp_data_in.leak_total    = trim(leak_count_in);
      rsp_data_in.leak_flag     = (leak_count_in != '0);
      rsp_data_in.leak_ready    = leak_armed_in;

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= pfm_pkg::BACK_IDLE;
         flow_count_ff   <= '0;
         screw_count_ff  <= '0;
         flow_last_ff    <= '0;
         screw_last_ff   <= '0;
         flow_fresh_ff   <= 1'b1;
         screw_fresh_ff  <= 1'b1;
         window_start_ff <= '0;
         window_base_ff  <= '0;
         held_rate_ff    <= '0;
         rearm_time_ff   <= '0;
         leak_base_ff    <= '0;
         leak_count_ff   <= '0;
         leak_armed_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         flow_count_ff   <= flow_count_in;
         screw_count_ff  <= screw_count_in;
         flow_last_ff    <= flow_last_in;
         screw_last_ff   <= screw_last_in;
         flow_fresh_ff   <= flow_fresh_in;
         screw_fresh_ff  <= screw_fresh_in;
         window_start_ff <= window_start_in;
         window_base_ff  <= window_base_in;
         held_rate_ff    <= held_rate_in;
         rearm_time_ff   <= rearm_time_in;
         leak_base_ff    <= leak_base_in;
         leak_count_ff   <= leak_count_in;
         leak_armed_ff   <= leak_armed_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hdl/pulse_flow_monitor.sv
// top level of the pulse flow monitor: request queue, execution back end, csr port
// most commands: the request enters the queue, then the back end loads the response register
// a rate poll with an elapsed window goes through BACK_MUL and BACK_DIV, where the divider makes
// one quotient bit per cycle; other commands retire one per cycle unless the response stalls
// a 2-entry queue lets requests be accepted while the back end divides or the response stalls
// synchronous reset clears counters and the queue and loads csr defaults; no clearing pass
module pulse_flow_monitor #(
   parameter int COUNT_WIDTH = pfm_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  pfm_pkg::req_payload_type               req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output pfm_pkg::rsp_payload_type               rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [pfm_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [pfm_pkg::CSR_DATA_WIDTH-1:0]     csr_data
);

   pfm_pkg::queue_entry_type head;
   logic                     head_pop;
   logic                     head_valid;

   assign csr_ready = 1'b1;

   pfm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .head       (head),
      .head_pop   (head_pop),
      .head_valid (head_valid)
   );

   pfm_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: hdl/pfm_checker.sv
// port-level checker for the pulse flow monitor and its bind
`include "assert_macros.svh"

module pfm_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input pfm_pkg::rsp_payload_type rsp_data
);

   `PFM_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "response changed while stalled")
   `PFM_ASSERT(a_leak_flag, rsp_valid |-> rsp_data.leak_flag == (rsp_data.leak_total != 32'd0), "leak flag disagrees with leak total")
   `PFM_ASSERT_ALWAYS(a_reset_rsp, reset |=> !rsp_valid, "response valid right after reset")
   `PFM_ASSERT_ALWAYS(a_reset_req, reset |=> req_ready, "request not ready right after reset")

endmodule

bind pulse_flow_monitor pfm_checker u_pfm_checker (.*);

FILE: tb/sv/tb_top.sv
// self-checking testbench for the pulse flow monitor: edges, rate polls, leak watch and csr
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam logic [pfm_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE = 2'd3;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned QUIET_LIMIT  = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   pfm_pkg::req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   pfm_pkg::rsp_payload_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [pfm_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [pfm_pkg::CSR_DATA_WIDTH-1:0]  csr_data = '0;

   pulse_flow_monitor u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // monitor model state
   logic [pfm_pkg::GAP_WIDTH-1:0]    flow_gap;
   logic [pfm_pkg::GAP_WIDTH-1:0]    screw_gap;
   logic [pfm_pkg::WINDOW_WIDTH-1:0] rate_window;
   logic [31:0] flow_pulses, screw_pulses, flow_last_us, screw_last_us;
   bit          flow_first, screw_first;
   logic [31:0] window_start_ms, window_base, held_rate, rearm_ms;
   logic [31:0] leak_base, leak_pulses;
   bit          leak_armed;

   pfm_pkg::rsp_payload_type pending_status[$];
   int unsigned mismatches = 0;
   bit          idle_on = 1'b1;
   bit          req_live = 1'b0;
   int unsigned rsp_hold = 0;
   int unsigned quiet_cycles = 0;
   logic [31:0] now_us = '0;
   logic [31:0] now_ms = '0;

   function automatic void restart_monitor(input logic [31:0] start_ms);
      flow_pulses = '0;
      screw_pulses = '0;
      flow_last_us = '0;
      screw_last_us = '0;
      flow_first = 1'b1;
      screw_first = 1'b1;
      window_start_ms = start_ms;
      window_base = '0;
      held_rate = '0;
      rearm_ms = start_ms;
      leak_base = '0;
      leak_pulses = '0;
      leak_armed = 1'b0;
   endfunction

   function automatic bit gap_cleared(input bit fresh, input logic [31:0] stamp, last,
                                      input logic [pfm_pkg::GAP_WIDTH-1:0] min_gap);
      logic [31:0] since;
      since = stamp - last;
      return fresh || (since >= {12'd0, min_gap});
   endfunction

   function automatic pfm_pkg::rsp_payload_type predict_status(
         input pfm_pkg::req_payload_type item);
      pfm_pkg::rsp_payload_type st;
      logic [31:0] elapsed, span, scaled, rearm_wait;
      bit hit;
      hit = 1'b0;
      case (item.opcode)
         pfm_pkg::OP_FLOW_EDGE: begin
            hit = gap_cleared(flow_first, item.time_us, flow_last_us, flow_gap);
            if (hit) begin
               flow_first = 1'b0;
               flow_last_us = item.time_us;
               flow_pulses = flow_pulses + 32'd1;
            end
         end
         pfm_pkg::OP_SCREW_EDGE: begin
            hit = gap_cleared(screw_first, item.time_us, screw_last_us, screw_gap);
            if (hit) begin
               screw_first = 1'b0;
               screw_last_us = item.time_us;
               screw_pulses = screw_pulses + 32'd1;
            end
         end
         pfm_pkg::OP_RATE_POLL: begin
            elapsed = item.time_ms - window_start_ms;
            span = (rate_window == '0) ? 32'd1 : {16'd0, rate_window};
            if (elapsed >= span) begin
               scaled = (flow_pulses - window_base) * 32'd1000;
               held_rate = scaled / elapsed;
               window_base = flow_pulses;
               window_start_ms = item.time_ms;
            end
         end
         pfm_pkg::OP_LEAK_POLL: begin
            if (item.pump_running) begin
               leak_armed = 1'b0;
               leak_base = flow_pulses;
            end else if (!leak_armed) begin
               rearm_wait = item.time_ms - rearm_ms;
               if (!rearm_wait[31]) leak_armed = 1'b1;
               leak_base = flow_pulses;
            end else if (flow_pulses > leak_base) begin
               leak_pulses = leak_pulses + (flow_pulses - leak_base);
               leak_base = flow_pulses;
            end
         end
         pfm_pkg::OP_LEAK_REARM: begin
            rearm_ms = item.rearm_time_ms;
            leak_armed = 1'b0;
            leak_base = flow_pulses;
         end
         pfm_pkg::OP_START: begin
            restart_monitor(item.time_ms);
         end
         default: begin
         end
      endcase
      st.edge_accepted = hit;
      st.flow_total = flow_pulses;
      st.screw_total = screw_pulses;
      st.flow_rate = held_rate;
      st.leak_total = leak_pulses;
      st.leak_flag = (leak_pulses != '0);
      st.leak_ready = leak_armed;
      return st;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic pfm_pkg::req_payload_type make_item(input logic [2:0] op,
                                                          input logic [31:0] t_us,
                                                          input logic [31:0] t_ms,
                                                          input bit pump,
                                                          input logic [31:0] rearm);
      pfm_pkg::req_payload_type it;
      it.opcode = op;
      it.time_us = t_us;
      it.time_ms = t_ms;
      it.pump_running = pump;
      it.rearm_time_ms = rearm;
      return it;
   endfunction

   // mostly well-formed readings that follow the monitor's own timing, some noise
   function automatic pfm_pkg::req_payload_type next_reading();
      pfm_pkg::req_payload_type it;
      int unsigned roll, pick;
      logic [31:0] span, base;
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 3);
      it = make_item(pfm_pkg::OP_FLOW_EDGE, now_us + $urandom_range(0, 40),
                     now_ms + $urandom_range(0, 2), 1'($urandom_range(0, 1)), $urandom());
      if (roll < 12) begin
         it.opcode = 3'($urandom_range(0, 7));
         it.time_us = $urandom();
         it.time_ms = $urandom();
         return it;
      end
      if (roll < 67) begin
         it.opcode = (roll < 52) ? pfm_pkg::OP_FLOW_EDGE : pfm_pkg::OP_SCREW_EDGE;
         span = (roll < 52) ? {12'd0, flow_gap} : {12'd0, screw_gap};
         base = (roll < 52) ? flow_last_us : screw_last_us;
         case (pick)
            0: it.time_us = base + span - 32'd1;
            1: it.time_us = base + span;
            2: it.time_us = base + span + 32'd1;
            default: it.time_us = base + $urandom_range(0, 2 * span + 20);
         endcase
      end else if (roll < 79) begin
         it.opcode = pfm_pkg::OP_RATE_POLL;
         span = (rate_window == '0) ? 32'd1 : {16'd0, rate_window};
         case (pick)
            0: it.time_ms = window_start_ms + span - 32'd1;
            1: it.time_ms = window_start_ms + span;
            default: it.time_ms = window_start_ms + $urandom_range(0, 2 * span + 4);
         endcase
      end else if (roll < 92) begin
         it.opcode = pfm_pkg::OP_LEAK_POLL;
         it.pump_running = ($urandom_range(0, 2) == 0);
         case (pick)
            0: it.time_ms = rearm_ms - 32'd1;
            1: it.time_ms = rearm_ms;
            default: it.time_ms = now_ms + $urandom_range(0, 40);
         endcase
      end else if (roll < 98) begin
         it.opcode = pfm_pkg::OP_LEAK_REARM;
         if (pick != 0) it.rearm_time_ms = now_ms + $urandom_range(0, 60);
      end else begin
         it.opcode = pfm_pkg::OP_START;
         if (pick == 0) it.time_ms = $urandom();
      end
      now_us = it.time_us;
      now_ms = it.time_ms;
      return it;
   endfunction

   task automatic send_reading(input pfm_pkg::req_payload_type item);
      int unsigned gap;
      gap = idle_on ? pick_gap() : 0;
      if (gap > 0 && req_live) req_valid <= 1'b0;
      repeat (gap) @(posedge clock);
      req_valid <= 1'b1;
      req_data <= item;
      req_live = 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_status.push_back(predict_status(item));
   endtask

   task automatic stop_sending();
      if (req_live) begin
         req_valid <= 1'b0;
         req_live = 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      stop_sending();
      while (pending_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [pfm_pkg::CSR_INDEX_WIDTH-1:0] index,
                            input logic [pfm_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         pfm_pkg::CSR_FLOW_GAP: flow_gap = value[pfm_pkg::GAP_WIDTH-1:0];
         pfm_pkg::CSR_SCREW_GAP: screw_gap = value[pfm_pkg::GAP_WIDTH-1:0];
         pfm_pkg::CSR_RATE_WINDOW: rate_window = value[pfm_pkg::WINDOW_WIDTH-1:0];
         default: begin
         end
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_settings(input logic [pfm_pkg::GAP_WIDTH-1:0] fgap,
                                 input logic [pfm_pkg::GAP_WIDTH-1:0] sgap,
                                 input logic [pfm_pkg::WINDOW_WIDTH-1:0] win);
      logic [31:0] junk;
      wait_drained();
      junk = $urandom();
      write_csr(pfm_pkg::CSR_FLOW_GAP, {junk[31:pfm_pkg::GAP_WIDTH], fgap});
      junk = $urandom();
      write_csr(pfm_pkg::CSR_SCREW_GAP, {junk[31:pfm_pkg::GAP_WIDTH], sgap});
      junk = $urandom();
      write_csr(pfm_pkg::CSR_RATE_WINDOW, {junk[31:pfm_pkg::WINDOW_WIDTH], win});
   endtask

   task automatic run_traffic(input int unsigned count);
      repeat (count) send_reading(next_reading());
   endtask

   task automatic test_edge_gaps();
      send_reading(make_item(pfm_pkg::OP_START, 32'd0, 32'd0, 1'b0, 32'd0));
      send_reading(make_item(pfm_pkg::OP_FLOW_EDGE, 32'd5, 32'd0, 1'b0, 32'd0));
      send_reading(make_item(pfm_pkg::OP_FLOW_EDGE, 32'd1004, 32'd1, 1'b0, 32'd0));
      send_reading(make_item(pfm_pkg::OP_FLOW_EDGE, 32'd1005, 32'd1, 1'b0, 32'd0));
      send_reading(make_item(pfm_pkg::OP_SCREW_EDGE, 32'd100, 32'd1, 1'b0, 32'd0));
      send_reading(make_item(pfm_pkg::OP_SCREW_EDGE, 32'd5099, 32'd5, 1'b0, 32'd0));
      send_reading(make_item(pfm_pkg::OP_SCREW_EDGE, 32'd5100, 32'd5, 1'b0, 32'd0));
      send_reading(make_item(pfm_pkg::OP_FLOW_EDGE, 32'hFFFF_FF00, 32'd6, 1'b0, 32'd0));
      send_reading(make_item(pfm_pkg::OP_FLOW_EDGE, 32'h0000_02E7, 32'd7, 1'b0, 32'd0));
      send_reading(make_item(pfm_pkg::OP_FLOW_EDGE, 32'h0000_02E8, 32'd7, 1'b0, 32'd0));
   endtask

   task automatic test_rate_window();
      send_reading(make_item(pfm_pkg::OP_RATE_POLL, 32'd0, 32'd999, 1'b0, 32'd0));
      send_reading(make_item(pfm_pkg::OP_RATE_POLL, 32'd0, 32'd1000, 1'b0, 32'd0));
      send_reading(make_item(pfm_pkg::OP_FLOW_EDGE, 32'h0000_1000, 32'd1001, 1'b0, 32'd0));
      send_reading(make_item(pfm_pkg::OP_RATE_POLL, 32'd0, 32'd1003, 1'b0, 32'd0));
   endtask

   task automatic test_leak_watch();
      send_reading(make_item(pfm_pkg::OP_LEAK_POLL, 32'd0, 32'd2000, 1'b1, 32'd0));
      send_reading(make_item(pfm_pkg::OP_LEAK_REARM, 32'd0, 32'd2000, 1'b0, 32'd5000));
      send_reading(make_item(pfm_pkg::OP_LEAK_POLL, 32'd0, 32'd4999, 1'b0, 32'd0));
      send_reading(make_item(pfm_pkg::OP_LEAK_POLL, 32'd0, 32'd5000, 1'b0, 32'd0));
      send_reading(make_item(pfm_pkg::OP_FLOW_EDGE, 32'h0000_2000, 32'd5000, 1'b0, 32'd0));
      send_reading(make_item(pfm_pkg::OP_LEAK_POLL, 32'd0, 32'd5001, 1'b0, 32'd0));
   endtask

   task automatic test_unused_codes();
      send_reading(make_item(OP_SPARE_LO, '1, '1, 1'b1, '1));
      send_reading(make_item(OP_SPARE_HI, '1, '1, 1'b1, '1));
      send_reading(make_item(pfm_pkg::OP_START, '1, '1, 1'b1, '1));
      send_reading(make_item(pfm_pkg::OP_FLOW_EDGE, '1, '1, 1'b1, '1));
      send_reading(make_item(pfm_pkg::OP_LEAK_POLL, '0, '0, 1'b0, '0));
   endtask

   task automatic test_default_traffic();
      idle_on = 1'b0;
      now_us = 32'd8192;
      now_ms = 32'd5001;
      run_traffic(100);
      idle_on = 1'b1;
   endtask

   task automatic test_low_extremes();
      write_settings('0, '0, '0);
      run_traffic(90);
   endtask

   task automatic test_high_extremes();
      write_settings('1, '1, '1);
      write_csr(CSR_SPARE, $urandom());
      now_us = 32'hFFFF_0000;
      now_ms = 32'hFFFF_FF00;
      send_reading(make_item(pfm_pkg::OP_START, now_us, now_ms, 1'b0, 32'd0));
      run_traffic(90);
   endtask

   task automatic test_random_settings();
      repeat (3) begin
         write_settings(pfm_pkg::GAP_WIDTH'($urandom_range(0, 3000)),
                        pfm_pkg::GAP_WIDTH'($urandom_range(0, 8000)),
                        pfm_pkg::WINDOW_WIDTH'($urandom_range(1, 2000)));
         run_traffic(90);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : status_check
      pfm_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_status.size() == 0) begin
            $display("%0t unexpected transaction: expected none, actual %h", $time, rsp_data);
            mismatches++;
         end else begin
            want = pending_status.pop_front();
            check_field("edge_accepted", 32'(want.edge_accepted), 32'(rsp_data.edge_accepted));
            check_field("flow_total", want.flow_total, rsp_data.flow_total);
            check_field("screw_total", want.screw_total, rsp_data.screw_total);
            check_field("flow_rate", want.flow_rate, rsp_data.flow_rate);
            check_field("leak_total", want.leak_total, rsp_data.leak_total);
            check_field("leak_flag", 32'(want.leak_flag), 32'(rsp_data.leak_flag));
            check_field("leak_ready", 32'(want.leak_ready), 32'(rsp_data.leak_ready));
         end
      end
   end

   always @(posedge clock) begin : rsp_pacing
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < 25) begin
         rsp_hold = pick_gap();
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   initial begin
      flow_gap = pfm_pkg::FLOW_GAP_RESET;
      screw_gap = pfm_pkg::SCREW_GAP_RESET;
      rate_window = pfm_pkg::RATE_WINDOW_RESET;
      restart_monitor(32'd0);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_edge_gaps();
      test_rate_window();
      test_leak_watch();
      test_unused_codes();
      test_default_traffic();
      test_low_extremes();
      test_high_extremes();
      test_random_settings();
      wait_drained();
      if (mismatches == 0 && pending_status.size() == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
